@@ sv/rft_pkg.sv @@
package rft_pkg;

  localparam logic [7:0] STATUS_GOOD = 8'h00;
  localparam logic [7:0] STATUS_BAD  = 8'hFF;

  typedef enum logic [1:0] {
    OP_STORE  = 2'd0,
    OP_INVAL  = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef struct packed {
    logic store;
    logic inval;
    logic start;
    logic scan_adv;
    logic res_load;
    logic res_hit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic fill_zero;
    logic hit;
    logic last;
  } sts_t;

endpackage

@@ sv/reply_frame_table.sv @@
// Store and invalidate: no result, one per cycle while no search is in progress.
// Search: result registered on the first hit, or as a miss after the last filled slot.
// The scan reads one slot per cycle from the type and status RAMs; a search
// holds the input until its result enters the output register.
// Reset (async, active low) clears fill count, write slot and handshake
// state; table contents stay undefined until written.
module reply_frame_table import rft_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] op_i,
  input  logic [7:0] entry_type_i,
  input  logic [7:0] entry_status_i,
  input  logic [3:0] slot_index_i,
  input  logic [7:0] search_key_i,
  input  logic       compare_mode_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       found_o,
  output logic [3:0] found_slot_o
);

  cmd_t cmd;
  sts_t sts;

  rft_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  rft_dp #(.TableDepth(TABLE_DEPTH)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .entry_type_i   (entry_type_i),
    .entry_status_i (entry_status_i),
    .slot_index_i   (slot_index_i),
    .search_key_i   (search_key_i),
    .compare_mode_i (compare_mode_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .found_o        (found_o),
    .found_slot_o   (found_slot_o)
  );

endmodule

@@ sv/rft_ram.sv @@
module rft_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [AddrW-1:0]       waddr_i,
  input  logic [Width-1:0]       wdata_i,
  input  logic                   re_i,
  input  logic [AddrW-1:0]       raddr_i,
  output logic [Width-1:0]       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/rft_ctrl.sv @@
module rft_ctrl import rft_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] op_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output cmd_t       cmd_o,
  input  sts_t       sts_i
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_PUSH = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  op_e    op;

  assign op         = op_e'(op_i);
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_STORE: cmd_o.store = 1'b1;
            OP_INVAL: cmd_o.inval = 1'b1;
            OP_SEARCH: begin
              cmd_o.start = 1'b1;
              if (sts_i.fill_zero) begin
                cmd_o.res_load = 1'b1;
                state_d        = S_PUSH;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (sts_i.hit || sts_i.last) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_hit  = sts_i.hit;
          state_d        = S_PUSH;
        end else begin
          cmd_o.scan_adv = 1'b1;
        end
      end
      S_PUSH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !(out_valid_q && out_stall_i))
    else $error("result overwritten while held");

  a_scan_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |=> (state_q == S_SCAN || state_q == S_PUSH))
    else $error("scan left without pushing a result");

  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op == OP_SEARCH) |=> (state_q != S_IDLE))
    else $error("search accepted without work");

  a_push_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q)
    else $error("pushed result not presented");

endmodule

@@ sv/rft_dp.sv @@
module rft_dp import rft_pkg::*; #(
  parameter int unsigned TableDepth = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] entry_type_i,
  input  logic [7:0] entry_status_i,
  input  logic [3:0] slot_index_i,
  input  logic [7:0] search_key_i,
  input  logic       compare_mode_i,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  output logic       found_o,
  output logic [3:0] found_slot_o
);

  localparam int unsigned AW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned FW = $clog2(TableDepth + 1);
  localparam logic [AW-1:0] LastSlot = AW'(TableDepth - 1);
  localparam logic [FW-1:0] FullCount = FW'(TableDepth);

  logic [AW-1:0] write_slot_q, write_slot_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [AW-1:0] chk_idx_q;
  logic [7:0]    key_q;
  logic          mode_q;
  logic          res_found_q;
  logic [3:0]    res_slot_q;
  logic          found_q;
  logic [3:0]    found_slot_q;

  logic          inval_ok;
  logic          type_we, status_we;
  logic [AW-1:0] status_waddr;
  logic [7:0]    status_wdata;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    type_rd, status_rd;
  logic          match;

  assign inval_ok     = (9'(slot_index_i) < 9'(TableDepth));
  assign type_we      = cmd_i.store;
  assign status_we    = cmd_i.store || (cmd_i.inval && inval_ok);
  assign status_waddr = cmd_i.store ? write_slot_q : AW'(slot_index_i);
  assign status_wdata = cmd_i.store ? entry_status_i : STATUS_BAD;
  assign rd_en        = cmd_i.start || cmd_i.scan_adv;
  assign rd_addr      = cmd_i.start ? '0 : AW'(chk_idx_q + AW'(1));

  rft_ram #(.Width(8), .Depth(TableDepth)) u_type_ram (
    .clk_i   (clk_i),
    .we_i    (type_we),
    .waddr_i (write_slot_q),
    .wdata_i (entry_type_i),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (type_rd)
  );

  rft_ram #(.Width(8), .Depth(TableDepth)) u_status_ram (
    .clk_i   (clk_i),
    .we_i    (status_we),
    .waddr_i (status_waddr),
    .wdata_i (status_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (status_rd)
  );

  assign match = mode_q ? (type_rd > key_q) : (type_rd == key_q);

  assign sts_o.fill_zero = (fill_q == '0);
  assign sts_o.hit       = (status_rd == STATUS_GOOD) && match;
  assign sts_o.last      = (FW'(chk_idx_q) + FW'(1) == fill_q);

  always_comb begin
    write_slot_d = write_slot_q;
    fill_d       = fill_q;
    if (cmd_i.store) begin
      write_slot_d = (write_slot_q == LastSlot) ? '0 : AW'(write_slot_q + AW'(1));
      if (fill_q != FullCount) begin
        fill_d = FW'(fill_q + FW'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_slot_q <= '0;
      fill_q       <= '0;
    end else begin
      write_slot_q <= write_slot_d;
      fill_q       <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q     <= search_key_i;
      mode_q    <= compare_mode_i;
      chk_idx_q <= '0;
    end else if (cmd_i.scan_adv) begin
      chk_idx_q <= AW'(chk_idx_q + AW'(1));
    end
    if (cmd_i.res_load) begin
      res_found_q <= cmd_i.res_hit;
      res_slot_q  <= cmd_i.res_hit ? 4'(chk_idx_q) : 4'd0;
    end
    if (cmd_i.out_load) begin
      found_q      <= res_found_q;
      found_slot_q <= res_slot_q;
    end
  end

  assign found_o      = found_q;
  assign found_slot_o = found_slot_q;

  a_scan_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_adv |-> (FW'(chk_idx_q) + FW'(1) < fill_q))
    else $error("scan ran past filled slots");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FullCount)
    else $error("fill count above depth");

endmodule
